>>> hw/rtl/dlpg_pkg.sv
// Shared types and codes for the DDA line point generator.
package dlpg_pkg;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_START  = 2'd0;
  localparam kind_t KIND_STEP   = 2'd1;
  localparam kind_t KIND_NOLINE = 2'd2;

  typedef struct packed {
    logic  load;
    logic  prep;
    logic  div_step;
    logic  adv;
    logic  emit;
    kind_t kind;
  } dlpg_cmd_t;

  typedef struct packed {
    logic line_active;
    logic div_last;
    logic out_free;
  } dlpg_sts_t;

endpackage

>>> hw/rtl/dlpg_ctrl.sv
// Sequencer for the DDA line point generator: accept, prepare, divide, emit.
module dlpg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  output dlpg_pkg::dlpg_cmd_t cmd,
  input  dlpg_pkg::dlpg_sts_t sts
);
  import dlpg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  kind_t      kind_r, kind_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    cmd          = '0;
    cmd.kind     = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_START) begin
            cmd.load  = 1'b1;
            kind_nxt  = KIND_START;
            state_nxt = ST_PREP;
          end else if (sts.line_active) begin
            // advance accumulators on the accepting edge
            cmd.adv   = 1'b1;
            kind_nxt  = KIND_STEP;
            state_nxt = ST_EMIT;
          end else begin
            kind_nxt  = KIND_NOLINE;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= KIND_START;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

>>> hw/rtl/dlpg_datapath.sv
// Datapath: endpoint capture, restoring dividers, accumulators and output register.
module dlpg_datapath #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [COORD_BITS-1:0] in_x_start,
  input  logic signed [COORD_BITS-1:0] in_y_start,
  input  logic signed [COORD_BITS-1:0] in_x_end,
  input  logic signed [COORD_BITS-1:0] in_y_end,
  input  dlpg_pkg::dlpg_cmd_t          cmd,
  output dlpg_pkg::dlpg_sts_t          sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x_point,
  output logic signed [COORD_BITS-1:0] out_y_point,
  output logic                         out_last,
  output logic                         out_no_line
);
  import dlpg_pkg::*;

  localparam int AW = COORD_BITS + FRAC_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS);
  localparam logic [AW:0]   HALF     = (AW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS - 1);

  logic signed [COORD_BITS-1:0] xs_r, ys_r, xe_r, ye_r;
  logic signed [AW-1:0]         accx_r, accy_r;
  logic [QW-1:0]                qx_r, qy_r;
  logic                         negx_r, negy_r;
  logic [DW-1:0]                remx_r, remy_r;
  logic [DW-1:0]                steps_r, idx_r;
  logic                         active_r;
  logic [CW-1:0]                cnt_r;
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                         out_last_r, out_no_line_r;

  // line setup
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        adx, ady, stp;
  // divider step
  logic [DW:0]          remx2, remy2;
  logic                 gex, gey;
  // accumulate and round
  logic [AW-1:0]        incx, incy;
  logic [AW:0]          rndx, rndy;
  logic                 last_step;

  always_comb begin
    dx  = DW'(xe_r) - DW'(xs_r);
    dy  = DW'(ye_r) - DW'(ys_r);
    adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
    stp = (adx > ady) ? adx : ady;

    remx2 = {remx_r, 1'b0};
    remy2 = {remy_r, 1'b0};
    gex   = (remx2 >= {1'b0, steps_r});
    gey   = (remy2 >= {1'b0, steps_r});

    incx = {{(AW - QW){1'b0}}, qx_r};
    incy = {{(AW - QW){1'b0}}, qy_r};

    // half away from zero: add half, minus one ulp when negative, then floor
    rndx = {accx_r[AW-1], accx_r} + HALF - (AW + 1)'(accx_r[AW-1]);
    rndy = {accy_r[AW-1], accy_r} + HALF - (AW + 1)'(accy_r[AW-1]);

    last_step = (idx_r >= steps_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_r <= in_x_start;
      ys_r <= in_y_start;
      xe_r <= in_x_end;
      ye_r <= in_y_end;
    end
    if (cmd.prep) begin
      accx_r  <= {xs_r, {FRAC_BITS{1'b0}}};
      accy_r  <= {ys_r, {FRAC_BITS{1'b0}}};
      negx_r  <= dx[DW-1];
      negy_r  <= dy[DW-1];
      // integer quotient bit is one only when the delta equals the step count
      remx_r  <= (adx == stp) ? '0 : adx;
      remy_r  <= (ady == stp) ? '0 : ady;
      qx_r    <= {{FRAC_BITS{1'b0}}, (adx == stp)};
      qy_r    <= {{FRAC_BITS{1'b0}}, (ady == stp)};
      steps_r <= stp;
      cnt_r   <= '0;
    end else if (cmd.div_step) begin
      remx_r <= gex ? DW'(remx2 - {1'b0, steps_r}) : remx2[DW-1:0];
      remy_r <= gey ? DW'(remy2 - {1'b0, steps_r}) : remy2[DW-1:0];
      qx_r   <= {qx_r[QW-2:0], gex};
      qy_r   <= {qy_r[QW-2:0], gey};
      cnt_r  <= cnt_r + 1'b1;
    end else if (cmd.adv) begin
      accx_r <= negx_r ? accx_r - incx : accx_r + incx;
      accy_r <= negy_r ? accy_r - incy : accy_r + incy;
    end
    if (cmd.emit) begin
      case (cmd.kind)
        KIND_START: begin
          out_x_r       <= xs_r;
          out_y_r       <= ys_r;
          out_last_r    <= (steps_r == '0);
          out_no_line_r <= 1'b0;
        end
        KIND_STEP: begin
          out_x_r       <= rndx[FRAC_BITS +: COORD_BITS];
          out_y_r       <= rndy[FRAC_BITS +: COORD_BITS];
          out_last_r    <= last_step;
          out_no_line_r <= 1'b0;
        end
        default: begin
          out_x_r       <= '0;
          out_y_r       <= '0;
          out_last_r    <= 1'b0;
          out_no_line_r <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.prep) begin
        active_r <= (stp != '0);
        idx_r    <= '0;
      end else if (cmd.adv) begin
        idx_r <= idx_r + 1'b1;
      end else if (cmd.emit && cmd.kind == KIND_STEP && last_step) begin
        active_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts             = '0;
    sts.line_active = active_r;
    sts.div_last    = (cnt_r == CNT_LAST);
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_x_point = out_x_r;
  assign out_y_point = out_y_r;
  assign out_last    = out_last_r;
  assign out_no_line = out_no_line_r;

endmodule

>>> hw/rtl/dda_line_point_generator.sv
// DDA line point generator: one point out per item in.
//
// Input channel (in_valid/in_ready): in_func = 0 is a start beat carrying both
// endpoints, in_func = 1 asks for the next point of the current line.
// Output channel (out_valid/out_ready): one beat per input beat with the point,
// a last flag on the line's end point, and no_line when a next beat arrives
// with no line in progress (point fields and last are zero then).
// A next beat goes from idle to the emit state; its result is registered once the
// output register is free, and in_ready comes back in that same cycle. A start
// beat goes through the prepare, divide and emit states. Two restoring dividers
// make the per-step increments in the divide state, one quotient bit per cycle.
// Items are handled one at a time; in_ready is high whenever the sequencer is
// idle, also while a finished result waits in the output register.
// A stalled receiver holds the result in the output register; a finished item
// then waits for the register to free before it is written.
// Reset (rst_n low, synchronous) drops any line in progress and empties the
// output register; the first next beat after reset gives no_line.
module dda_line_point_generator #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic signed [COORD_BITS-1:0] in_x_start,
  input  logic signed [COORD_BITS-1:0] in_y_start,
  input  logic signed [COORD_BITS-1:0] in_x_end,
  input  logic signed [COORD_BITS-1:0] in_y_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_x_point,
  output logic signed [COORD_BITS-1:0] out_y_point,
  output logic                         out_last,
  output logic                         out_no_line
);
  import dlpg_pkg::*;

  dlpg_cmd_t cmd;
  dlpg_sts_t sts;

  dlpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  dlpg_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_x_start  (in_x_start),
    .in_y_start  (in_y_start),
    .in_x_end    (in_x_end),
    .in_y_end    (in_y_end),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x_point (out_x_point),
    .out_y_point (out_y_point),
    .out_last    (out_last),
    .out_no_line (out_no_line)
  );

endmodule

>>> hw/rtl/dlpg_checker.sv
// Port-level checks for the DDA line point generator, bound to the top level.
module dlpg_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] out_x_point,
  input logic [COORD_BITS-1:0] out_y_point,
  input logic                  out_last,
  input logic                  out_no_line
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x_point)
      && $stable(out_y_point) && $stable(out_last) && $stable(out_no_line))
    else $error("stalled result beat changed");

  a_no_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_line |-> out_x_point == '0 && out_y_point == '0 && !out_last)
    else $error("no_line beat carries a point");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // a new result appears as the sequencer goes back to idle
  a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while the sequencer was busy");

endmodule

bind dda_line_point_generator dlpg_checker #(.COORD_BITS(COORD_BITS)) u_dlpg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_x_point (out_x_point),
  .out_y_point (out_y_point),
  .out_last    (out_last),
  .out_no_line (out_no_line)
);

>>> dv/tb_dda_line_point_generator.sv
// Self-checking testbench for the DDA line point generator.
module tb_dda_line_point_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import dlpg_pkg::*;

  localparam int COORD_W    = 12;
  localparam int FRAC_W     = 16;
  localparam int ACC_W      = COORD_W + FRAC_W;
  localparam int C_MIN      = -(1 << (COORD_W - 1));
  localparam int C_MAX      = (1 << (COORD_W - 1)) - 1;
  localparam int TOTAL_BEATS = 620;
  localparam int CALM_FROM  = 540;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 2 * (FRAC_W + 2) + 4;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
    logic                      no_line;
  } point_t;

  class dda_scoreboard;
    point_t                  expected_q[$];
    int                      mismatches;
    int                      points_checked;
    int                      starts_seen;
    int                      nexts_seen;
    int                      no_lines_seen;
    int                      lasts_seen;
    logic signed [ACC_W-1:0] acc_x, acc_y, inc_x, inc_y;
    int unsigned             step_idx, step_cnt;
    bit                      active;

    function new();
      mismatches = 0;
      points_checked = 0;
      starts_seen = 0;
      nexts_seen = 0;
      no_lines_seen = 0;
      lasts_seen = 0;
      acc_x = '0;
      acc_y = '0;
      inc_x = '0;
      inc_y = '0;
      step_idx = 0;
      step_cnt = 0;
      active = 1'b0;
    endfunction

    // Round half away from zero, then keep the coordinate width.
    function logic signed [COORD_W-1:0] round_acc(logic signed [ACC_W-1:0] a);
      longint v, half, r;
      v = a;
      half = longint'(1) << (FRAC_W - 1);
      if (v >= 0) r = (v + half) >>> FRAC_W;
      else r = -((-v + half) >>> FRAC_W);
      return r[COORD_W-1:0];
    endfunction

    function void note_input(logic func, logic signed [COORD_W-1:0] xs,
                             logic signed [COORD_W-1:0] ys,
                             logic signed [COORD_W-1:0] xe,
                             logic signed [COORD_W-1:0] ye);
      point_t p;
      longint dx, dy, adx, ady, steps, one;
      p.x = '0;
      p.y = '0;
      p.last = 1'b0;
      p.no_line = 1'b0;
      one = longint'(1) << FRAC_W;
      if (func == FUNC_START) begin
        starts_seen++;
        dx = longint'(xe) - longint'(xs);
        dy = longint'(ye) - longint'(ys);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        steps = adx > ady ? adx : ady;
        acc_x = {xs, {FRAC_W{1'b0}}};
        acc_y = {ys, {FRAC_W{1'b0}}};
        if (steps != 0) begin
          inc_x = ACC_W'((dx * one) / steps);
          inc_y = ACC_W'((dy * one) / steps);
        end else begin
          inc_x = '0;
          inc_y = '0;
        end
        step_idx = 0;
        step_cnt = int'(steps);
        active = (steps != 0);
        p.x = xs;
        p.y = ys;
        p.last = (steps == 0);
      end else begin
        nexts_seen++;
        if (!active) begin
          p.no_line = 1'b1;
        end else begin
          acc_x = acc_x + inc_x;
          acc_y = acc_y + inc_y;
          step_idx++;
          p.last = (step_idx >= step_cnt);
          if (p.last) active = 1'b0;
          p.x = round_acc(acc_x);
          p.y = round_acc(acc_y);
        end
      end
      expected_q.push_back(p);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(point_t got);
      point_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("point beat (%0d,%0d) with nothing expected",
                                  got.x, got.y));
        return;
      end
      want = expected_q.pop_front();
      points_checked++;
      if (got.no_line === 1'b1) no_lines_seen++;
      if (got.last === 1'b1) lasts_seen++;
      if (got.x !== want.x)
        report_mismatch($sformatf("x_point got %0d want %0d", got.x, want.x));
      if (got.y !== want.y)
        report_mismatch($sformatf("y_point got %0d want %0d", got.y, want.y));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %b want %b", got.last, want.last));
      if (got.no_line !== want.no_line)
        report_mismatch($sformatf("no_line got %b want %b", got.no_line, want.no_line));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_func = FUNC_START;
  logic signed [COORD_W-1:0] in_x_start = '0;
  logic signed [COORD_W-1:0] in_y_start = '0;
  logic signed [COORD_W-1:0] in_x_end = '0;
  logic signed [COORD_W-1:0] in_y_end = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [COORD_W-1:0] out_x_point;
  logic signed [COORD_W-1:0] out_y_point;
  logic                      out_last;
  logic                      out_no_line;

  dda_scoreboard sb = new();
  int  beats_sent = 0;
  int  tx_rate = 20;
  int  rx_rate = 20;
  int  rx_hold = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;
  int  drains = 0;

  dda_line_point_generator #(
    .COORD_BITS(COORD_W),
    .FRAC_BITS (FRAC_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_x_start (in_x_start),
    .in_y_start (in_y_start),
    .in_x_end   (in_x_end),
    .in_y_end   (in_y_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x_point(out_x_point),
    .out_y_point(out_y_point),
    .out_last   (out_last),
    .out_no_line(out_no_line)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: stall in bursts; no new burst starts during the calm tail.
  always @(posedge clk) begin
    if (rx_hold != 0) rx_hold = rx_hold - 1;
    else if (!calm && rx_rate != 0 && $urandom_range(0, 99) < rx_rate)
      rx_hold = $urandom_range(1, 11);
    out_ready <= (rx_hold == 0);
  end

  always @(posedge clk) begin
    point_t got;
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_func, in_x_start, in_y_start, in_x_end, in_y_end);
      if (out_valid && out_ready) begin
        got.x = out_x_point;
        got.y = out_y_point;
        got.last = out_last;
        got.no_line = out_no_line;
        sb.check_result(got);
      end
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int rand_coord();
    return int'($urandom_range(0, 4095)) + C_MIN;
  endfunction

  function automatic int clamp_coord(int v);
    return v < C_MIN ? C_MIN : (v > C_MAX ? C_MAX : v);
  endfunction

  function automatic int line_steps(int xs, int ys, int xe, int ye);
    int adx, ady;
    adx = xe > xs ? xe - xs : xs - xe;
    ady = ye > ys ? ye - ys : ys - ye;
    return adx > ady ? adx : ady;
  endfunction

  task automatic send_item(logic func, int xs, int ys, int xe, int ye);
    if (!calm && tx_rate != 0 && $urandom_range(0, 99) < tx_rate) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_func    <= func;
    in_x_start <= COORD_W'(xs);
    in_y_start <= COORD_W'(ys);
    in_x_end   <= COORD_W'(xe);
    in_y_end   <= COORD_W'(ye);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_start(int xs, int ys, int xe, int ye);
    send_item(FUNC_START, xs, ys, xe, ye);
  endtask

  // Endpoint fields are don't-care on a next beat; fill them with noise.
  task automatic send_next();
    send_item(FUNC_NEXT, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  // Hold off the sender until every outstanding point is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    drains++;
  endtask

  initial begin
    int sel, xs, ys, xe, ye, span, steps, n;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no line after reset, degenerate line, full-range lines,
    // restart mid-line, rounding of negative halves.
    send_next();
    send_start(5, -5, 5, -5);
    send_next();
    send_start(C_MIN, C_MIN, C_MAX, C_MAX);
    send_next();
    send_next();
    send_start(C_MAX, C_MIN, C_MIN, C_MAX);
    send_next();
    send_start(0, 0, -1, -2);
    send_next();
    send_next();
    send_next();
    send_start(-1, 0, 0, 2);
    send_next();
    send_next();
    send_start(C_MAX, 0, C_MAX - 3, C_MIN);
    send_next();
    send_start(-1, -1, -1, -1);
    send_start(C_MIN, C_MAX, C_MIN + 1, C_MAX);
    send_next();
    send_next();
    drain();

    while (beats_sent < TOTAL_BEATS) begin
      calm = (beats_sent >= CALM_FROM);
      if ($urandom_range(0, 9) == 0) begin
        tx_rate = $urandom_range(0, 2) * 20;
        rx_rate = $urandom_range(0, 2) * 20;
      end
      if ($urandom_range(0, 29) == 0) drain();
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        span = ($urandom_range(0, 4) == 0) ? 60 : 12;
        xs = rand_coord();
        ys = rand_coord();
        if ($urandom_range(0, 7) == 0) xs = $urandom_range(0, 1) ? C_MIN : C_MAX;
        xe = clamp_coord(xs + int'($urandom_range(0, 2 * span)) - span);
        ye = clamp_coord(ys + int'($urandom_range(0, 2 * span)) - span);
        steps = line_steps(xs, ys, xe, ye);
        send_start(xs, ys, xe, ye);
        n = steps;
        if ($urandom_range(0, 6) == 0) n = $urandom_range(0, steps);
        repeat (n) send_next();
        if (n == steps && $urandom_range(0, 4) == 0) send_next();
      end else if (sel < 80) begin
        // Long line, abandoned after a few points.
        send_start(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        repeat ($urandom_range(1, 6)) send_next();
      end else if (sel < 90) begin
        xs = rand_coord();
        ys = rand_coord();
        send_start(xs, ys, xs, ys);
        if ($urandom_range(0, 1) == 0) send_next();
      end else begin
        repeat ($urandom_range(1, 3)) send_next();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input beats: %0d line starts, %0d next requests, %0d drains.",
             beats_sent, sb.starts_seen, sb.nexts_seen, drains);
    $display("Checked %0d points (%0d line ends, %0d no-line), %0d mismatches.",
             sb.points_checked, sb.lasts_seen, sb.no_lines_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
